// ===== hdl/axis_aligned_box_nms_top_macros.svh =====
// Assertion macros used by the checker file of the box suppression block.
`ifndef AXIS_ALIGNED_BOX_NMS_TOP_MACROS_SVH
`define AXIS_ALIGNED_BOX_NMS_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk and held off during reset.
`define ANMS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and held off during reset.
`define ANMS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/anms_pkg.sv =====
// Shared types and constants of the box suppression block.
`timescale 1ns / 1ps

package anms_pkg;

	// Configuration register indexes.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 17;
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IOU_THRESHOLD = 2'd0,
		REG_EPS_OFFSET    = 2'd1
	} cfg_reg_t;

	localparam int THR_W           = 17;
	localparam int EPS_W           = 8;
	localparam logic [THR_W-1:0] THR_RESET = 17'd32768;
	localparam int FRAC_W          = 16;

	// Result fields and their places in the output tdata.
	localparam int KEPT_IDX_W  = 6;
	localparam int KEPT_TOT_W  = 7;
	localparam int OUT_IDX_LSB = 0;
	localparam int OUT_TOT_LSB = 6;
	localparam int OUT_OVF_BIT = 13;
	localparam int OUT_TDATA_W = 16;

	typedef logic [KEPT_IDX_W-1:0] kept_idx_t;
	typedef logic [KEPT_TOT_W-1:0] kept_tot_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic ld_we;
		logic latch_i;
		logic cmp_issue;
		logic flags_clr;
	} anms_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic pipe_busy;
		logic flag_i;
	} anms_stat_t;

endpackage

// ===== hdl/anms_datapath.sv =====
// Datapath: configuration registers, box and area stores, load arithmetic, overlap test pipeline and suppressed flags.
`timescale 1ns / 1ps

module anms_datapath #(
	parameter int MAX_BOXES   = 64,
	parameter int COORD_WIDTH = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [anms_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [anms_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic [4*COORD_WIDTH-1:0]         in_box,
	input  logic [$clog2(MAX_BOXES)-1:0]     ld_addr,
	input  logic [$clog2(MAX_BOXES)-1:0]     rd_addr,
	input  logic [$clog2(MAX_BOXES)-1:0]     flag_addr,
	input  anms_pkg::anms_cmd_t              cmd,
	output anms_pkg::anms_stat_t             stat
);

	localparam int CW      = COORD_WIDTH;
	localparam int IDX_W   = $clog2(MAX_BOXES);
	localparam int F_W     = CW + 2;
	localparam int AREA_W  = 2 * F_W;
	localparam int ASUM_W  = AREA_W + 1;
	localparam int UNI_W   = AREA_W + 2;
	localparam int UM_W    = UNI_W - 1;
	localparam int LO_W    = (UM_W + 1) / 2;
	localparam int HI_W    = UM_W - LO_W;
	localparam int THR_W   = anms_pkg::THR_W;
	localparam int EPS_W   = anms_pkg::EPS_W;
	localparam int CMP_W   = THR_W + UM_W;

	// Configuration registers.
	logic [THR_W-1:0] thr_q;
	logic [EPS_W-1:0] eps_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= anms_pkg::THR_RESET;
			eps_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				anms_pkg::REG_IOU_THRESHOLD: thr_q <= cfg_data[THR_W-1:0];
				anms_pkg::REG_EPS_OFFSET:    eps_q <= cfg_data[EPS_W-1:0];
				default: ;
			endcase
		end
	end

	// Padded width and height of the incoming box.
	logic signed [CW-1:0]  in_x0, in_y0, in_x1, in_y1;
	logic signed [F_W-1:0] ld_dw, ld_dh;

	assign in_x0 = in_box[CW-1:0];
	assign in_y0 = in_box[2*CW-1:CW];
	assign in_x1 = in_box[3*CW-1:2*CW];
	assign in_y1 = in_box[4*CW-1:3*CW];
	assign ld_dw = F_W'(in_x1) - F_W'(in_x0) + $signed(F_W'(eps_q));
	assign ld_dh = F_W'(in_y1) - F_W'(in_y0) + $signed(F_W'(eps_q));

	logic                  ld_v_s1;
	logic [IDX_W-1:0]      ld_idx_s1;
	logic signed [F_W-1:0] ld_dw_s1, ld_dh_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ld_v_s1 <= 1'b0;
		end else begin
			ld_v_s1 <= cmd.ld_we;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_we) begin
			ld_idx_s1 <= ld_addr;
			ld_dw_s1  <= ld_dw;
			ld_dh_s1  <= ld_dh;
		end
	end

	// Box and area stores, one write port and one registered read port each.
	logic [4*CW-1:0]          box_mem  [MAX_BOXES];
	logic signed [AREA_W-1:0] area_mem [MAX_BOXES];
	logic [4*CW-1:0]          bj_s1;
	logic signed [AREA_W-1:0] aj_s1;

	always_ff @(posedge clk) begin
		if (cmd.ld_we) begin
			box_mem[ld_addr] <= in_box;
		end
		bj_s1 <= box_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (ld_v_s1) begin
			area_mem[ld_idx_s1] <= ld_dw_s1 * ld_dh_s1;
		end
		aj_s1 <= area_mem[rd_addr];
	end

	// The kept box under test is held while later boxes stream past it.
	logic [4*CW-1:0]          bi_q;
	logic signed [AREA_W-1:0] ai_q;

	always_ff @(posedge clk) begin
		if (cmd.latch_i) begin
			bi_q <= bj_s1;
			ai_q <= aj_s1;
		end
	end

	// Overlap of box i and box j.
	logic signed [CW-1:0]  ix0, iy0, ix1, iy1, jx0, jy0, jx1, jy1;
	logic signed [CW-1:0]  mn_x, mx_x, mn_y, mx_y;
	logic signed [F_W-1:0] ov_w, ov_h;

	assign ix0 = bi_q[CW-1:0];
	assign iy0 = bi_q[2*CW-1:CW];
	assign ix1 = bi_q[3*CW-1:2*CW];
	assign iy1 = bi_q[4*CW-1:3*CW];
	assign jx0 = bj_s1[CW-1:0];
	assign jy0 = bj_s1[2*CW-1:CW];
	assign jx1 = bj_s1[3*CW-1:2*CW];
	assign jy1 = bj_s1[4*CW-1:3*CW];

	always_comb begin
		mn_x = (ix1 < jx1) ? ix1 : jx1;
		mx_x = (ix0 > jx0) ? ix0 : jx0;
		mn_y = (iy1 < jy1) ? iy1 : jy1;
		mx_y = (iy0 > jy0) ? iy0 : jy0;
		ov_w = F_W'(mn_x) - F_W'(mx_x) + $signed(F_W'(eps_q));
		ov_h = F_W'(mn_y) - F_W'(mx_y) + $signed(F_W'(eps_q));
	end

	// Compare pipeline valid bits and indexes.
	logic             v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic [IDX_W-1:0] j_s1, j_s2, j_s3, j_s4, j_s5, j_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s1 <= cmd.cmp_issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// Stage payloads: overlap, intersection, union, split product, full product.
	logic signed [F_W-1:0]    w_s2, h_s2;
	logic signed [ASUM_W-1:0] asum_s2, asum_s3;
	logic signed [AREA_W-1:0] inter_s3, inter_s4, inter_s5, inter_s6;
	logic                     pos_s3, pos_s4, ok_s5, ok_s6;
	logic signed [UNI_W-1:0]  uni_s4;
	logic [THR_W+LO_W-1:0]    plo_s5;
	logic [THR_W+HI_W-1:0]    phi_s5;
	logic [CMP_W-1:0]         prod_s6;
	logic [UM_W-1:0]          um;

	assign um = uni_s4[UM_W-1:0];

	always_ff @(posedge clk) begin
		j_s1     <= rd_addr;
		j_s2     <= j_s1;
		w_s2     <= ov_w;
		h_s2     <= ov_h;
		asum_s2  <= ASUM_W'(ai_q) + ASUM_W'(aj_s1);
		j_s3     <= j_s2;
		inter_s3 <= w_s2 * h_s2;
		pos_s3   <= (w_s2 > 0) && (h_s2 > 0);
		asum_s3  <= asum_s2;
		j_s4     <= j_s3;
		uni_s4   <= UNI_W'(asum_s3) - UNI_W'(inter_s3);
		inter_s4 <= inter_s3;
		pos_s4   <= pos_s3;
		j_s5     <= j_s4;
		plo_s5   <= thr_q * um[LO_W-1:0];
		phi_s5   <= thr_q * um[UM_W-1:LO_W];
		ok_s5    <= pos_s4 && (uni_s4 > 0);
		inter_s5 <= inter_s4;
		j_s6     <= j_s5;
		prod_s6  <= (CMP_W'(phi_s5) << LO_W) + CMP_W'(plo_s5);
		ok_s6    <= ok_s5;
		inter_s6 <= inter_s5;
	end

	// Suppression decision: inter * 65536 >= threshold * union.
	logic [CMP_W-1:0] inter_sh;
	logic             hit;

	assign inter_sh = CMP_W'($unsigned(inter_s6)) << anms_pkg::FRAC_W;
	assign hit      = v_s6 && ok_s6 && (inter_sh >= prod_s6);

	// Suppressed flags, cleared at the start of every set.
	logic [MAX_BOXES-1:0] flags_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
		end else if (cmd.flags_clr) begin
			flags_q <= '0;
		end else if (hit) begin
			flags_q[j_s6] <= 1'b1;
		end
	end

	assign stat.flag_i    = flags_q[flag_addr];
	assign stat.pipe_busy = v_s1 | v_s2 | v_s3 | v_s4 | v_s5 | v_s6;

endmodule

// ===== hdl/anms_ctrl.sv =====
// Controller: load counting, suppression sequencing and the result register.
`timescale 1ns / 1ps

module anms_ctrl #(
	parameter int MAX_BOXES = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          in_last,
	output logic                          out_valid,
	input  logic                          out_ready,
	output anms_pkg::kept_idx_t           out_idx,
	output logic                          out_last,
	output anms_pkg::kept_tot_t           out_total,
	output logic                          out_ovf,
	output logic [$clog2(MAX_BOXES)-1:0]  ld_addr,
	output logic [$clog2(MAX_BOXES)-1:0]  rd_addr,
	output logic [$clog2(MAX_BOXES)-1:0]  flag_addr,
	output anms_pkg::anms_cmd_t           cmd,
	input  anms_pkg::anms_stat_t          stat
);

	localparam int IDX_W = $clog2(MAX_BOXES);
	localparam int CNT_W = $clog2(MAX_BOXES + 1);
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_BOXES);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_START = 7'b0000010,
		S_OUTER = 7'b0000100,
		S_LATCH = 7'b0001000,
		S_SCAN  = 7'b0010000,
		S_DRAIN = 7'b0100000,
		S_FLUSH = 7'b1000000
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q, i_q, j_q, kept_q;
	logic             ovf_q, pend_v_q, out_valid_q;
	logic [IDX_W-1:0] pend_q;

	logic accept, out_free, at_end, keep_now, push_mid, push_last;

	// Handshake and command decode.
	always_comb begin
		in_ready      = (state_q == S_IDLE);
		accept        = in_valid && in_ready;
		out_free      = !out_valid_q || out_ready;
		at_end        = (i_q == cnt_q);
		keep_now      = (state_q == S_OUTER) && !at_end && !stat.flag_i
		                && (!pend_v_q || out_free);
		push_mid      = keep_now && pend_v_q;
		push_last     = (state_q == S_FLUSH) && out_free;
		cmd           = '0;
		cmd.ld_we     = accept && (cnt_q < MAX_CNT);
		cmd.flags_clr = (state_q == S_START);
		cmd.latch_i   = (state_q == S_LATCH);
		cmd.cmp_issue = (state_q == S_SCAN) && (j_q != cnt_q);
		ld_addr       = cnt_q[IDX_W-1:0];
		flag_addr     = i_q[IDX_W-1:0];
		rd_addr       = (state_q == S_SCAN) ? j_q[IDX_W-1:0] : i_q[IDX_W-1:0];
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			ovf_q       <= 1'b0;
			i_q         <= '0;
			j_q         <= '0;
			kept_q      <= '0;
			pend_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (push_mid || push_last) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (cmd.ld_we) begin
							cnt_q <= cnt_q + 1'b1;
						end else begin
							ovf_q <= 1'b1;
						end
						if (in_last) begin
							state_q <= S_START;
						end
					end
				end
				S_START: begin
					i_q      <= '0;
					kept_q   <= '0;
					pend_v_q <= 1'b0;
					state_q  <= S_OUTER;
				end
				S_OUTER: begin
					if (at_end) begin
						state_q <= S_FLUSH;
					end else if (stat.flag_i) begin
						i_q <= i_q + 1'b1;
					end else if (keep_now) begin
						pend_v_q <= 1'b1;
						kept_q   <= kept_q + 1'b1;
						state_q  <= S_LATCH;
					end
				end
				S_LATCH: begin
					j_q     <= i_q + 1'b1;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (j_q == cnt_q) begin
						state_q <= S_DRAIN;
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				S_DRAIN: begin
					if (!stat.pipe_busy) begin
						i_q     <= i_q + 1'b1;
						state_q <= S_OUTER;
					end
				end
				S_FLUSH: begin
					if (out_free) begin
						cnt_q   <= '0;
						ovf_q   <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Pending kept index and the result register payload.
	anms_pkg::kept_idx_t out_idx_q;
	anms_pkg::kept_tot_t out_total_q;
	logic                out_last_q, out_ovf_q;

	always_ff @(posedge clk) begin
		if (keep_now) begin
			pend_q <= i_q[IDX_W-1:0];
		end
		if (push_mid || push_last) begin
			out_idx_q   <= anms_pkg::kept_idx_t'(pend_q);
			out_last_q  <= push_last;
			out_total_q <= push_last ? anms_pkg::kept_tot_t'(kept_q) : '0;
			out_ovf_q   <= ovf_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_idx   = out_idx_q;
	assign out_last  = out_last_q;
	assign out_total = out_total_q;
	assign out_ovf   = out_ovf_q;

endmodule

// ===== hdl/axis_aligned_box_nms_top.sv =====
// Top level of the greedy IoU suppression block for axis-aligned boxes.
//
// Channel   Direction  Handshake                    Carries
// s_axis    in         s_axis_tvalid/s_axis_tready  one box per request, tlast closes the set
// m_axis    out        m_axis_tvalid/m_axis_tready  one kept index per request, tlast on final
// cfg       in         cfg_valid/cfg_ready          register index and write data
//
// Loading takes one box per cycle; the input is held off while a set is suppressed.
// Suppression steps past each suppressed box; for each kept box it latches the box, issues
// one compare per later box, then waits for the compare pipeline to drain.
// A kept index waits while the result register is still occupied; results are never dropped.
// Reset is asynchronous; no store clearing pass is needed after reset.
`timescale 1ns / 1ps

module axis_aligned_box_nms_top #(
	parameter int MAX_BOXES   = 64,
	parameter int COORD_WIDTH = 16,
	localparam int IN_TDATA_W = ((4 * COORD_WIDTH + 7) / 8) * 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// x_min, y_min, x_max, y_max from bit 0 up, zero padded to bytes
	input  logic [IN_TDATA_W-1:0]               s_axis_tdata,
	input  logic                                s_axis_tlast,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// kept_index [5:0], kept_total [12:6], overflow [13], zero padding [15:14]
	output logic [anms_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	output logic                                m_axis_tlast,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [anms_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [anms_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int IDX_W = $clog2(MAX_BOXES);

	anms_pkg::anms_cmd_t  cmd;
	anms_pkg::anms_stat_t stat;
	logic [IDX_W-1:0]     ld_addr, rd_addr, flag_addr;
	anms_pkg::kept_idx_t  out_idx;
	anms_pkg::kept_tot_t  out_total;
	logic                 out_ovf;

	// Configuration requests are always taken.
	assign cfg_ready = 1'b1;

	anms_ctrl #(
		.MAX_BOXES (MAX_BOXES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_last   (s_axis_tlast),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_idx   (out_idx),
		.out_last  (m_axis_tlast),
		.out_total (out_total),
		.out_ovf   (out_ovf),
		.ld_addr   (ld_addr),
		.rd_addr   (rd_addr),
		.flag_addr (flag_addr),
		.cmd       (cmd),
		.stat      (stat)
	);

	anms_datapath #(
		.MAX_BOXES   (MAX_BOXES),
		.COORD_WIDTH (COORD_WIDTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_box    (s_axis_tdata[4*COORD_WIDTH-1:0]),
		.ld_addr   (ld_addr),
		.rd_addr   (rd_addr),
		.flag_addr (flag_addr),
		.cmd       (cmd),
		.stat      (stat)
	);

	// Pack the result fields.
	always_comb begin
		m_axis_tdata = '0;
		m_axis_tdata[anms_pkg::OUT_IDX_LSB +: anms_pkg::KEPT_IDX_W] = out_idx;
		m_axis_tdata[anms_pkg::OUT_TOT_LSB +: anms_pkg::KEPT_TOT_W] = out_total;
		m_axis_tdata[anms_pkg::OUT_OVF_BIT] = out_ovf;
	end

endmodule

// ===== hdl/anms_checker.sv =====
// Port-level checker for the box suppression block, bound to the top level.
`timescale 1ns / 1ps
`include "axis_aligned_box_nms_top_macros.svh"

module anms_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_axis_tvalid,
	input logic                              s_axis_tready,
	input logic                              s_axis_tlast,
	input logic                              m_axis_tvalid,
	input logic                              m_axis_tready,
	input logic [anms_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
	input logic                              m_axis_tlast
);

	anms_pkg::kept_tot_t total;

	assign total = m_axis_tdata[anms_pkg::OUT_TOT_LSB +: anms_pkg::KEPT_TOT_W];

	// A stalled result keeps its payload.
	`ANMS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "result changed while stalled")

	// Input is closed only by an accepted final box.
	`ANMS_ASSERT_NOW(a_close_on_last, $fell(s_axis_tready), $past(s_axis_tvalid && s_axis_tlast), "input closed without a final box")

	// The final result always carries a nonzero kept count.
	`ANMS_ASSERT_NOW(a_total_last, m_axis_tvalid && m_axis_tlast, total != 0, "final result with zero kept count")

	// Other results carry no count.
	`ANMS_ASSERT_NOW(a_total_mid, m_axis_tvalid && !m_axis_tlast, total == 0, "count on a non-final result")

endmodule

bind axis_aligned_box_nms_top anms_checker u_anms_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tlast  (s_axis_tlast),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);

// ===== sim/axis_aligned_box_nms_top_tb.sv =====
// Self-checking testbench for the axis-aligned box suppression block.
`timescale 1ns / 1ps

module axis_aligned_box_nms_top_tb;

	localparam int NBOX = 64;
	localparam int CW = 16;
	localparam int STALL_LIMIT = 20000;

	// One box request as it is queued for the input stream.
	typedef struct {
		logic signed [CW-1:0] x0;
		logic signed [CW-1:0] y0;
		logic signed [CW-1:0] x1;
		logic signed [CW-1:0] y1;
		logic last;
	} box_t;

	// One kept-index result as the output stream should carry it.
	typedef struct {
		anms_pkg::kept_idx_t idx;
		logic fin;
		anms_pkg::kept_tot_t total;
		logic ovf;
	} kept_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [4*CW-1:0] s_axis_tdata = '0;
	logic s_axis_tlast = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [anms_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
	logic m_axis_tlast;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [anms_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [anms_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	// Boxes waiting to be sent and kept indices waiting to be seen.
	box_t box_q[$];
	kept_t kept_q[$];
	box_t cur_box;
	int boxes_queued = 0;
	int boxes_taken = 0;
	int src_wait = 0;
	int snk_wait = 0;
	bit src_idle_on = 1'b1;
	bit snk_idle_on = 1'b1;
	int miss_cnt = 0;
	int stall_cycles = 0;

	// Mirror of the block's configuration and of the set being loaded.
	logic [anms_pkg::THR_W-1:0] thr_cfg = anms_pkg::THR_RESET;
	logic [anms_pkg::EPS_W-1:0] eps_cfg = '0;
	logic signed [CW-1:0] st_x0 [NBOX];
	logic signed [CW-1:0] st_y0 [NBOX];
	logic signed [CW-1:0] st_x1 [NBOX];
	logic signed [CW-1:0] st_y1 [NBOX];
	logic signed [35:0] st_area [NBOX];
	int set_len = 0;
	bit set_dropped = 1'b0;

	axis_aligned_box_nms_top #(
		.MAX_BOXES(NBOX),
		.COORD_WIDTH(CW)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	function automatic int draw_gap(bit idle_on);
		if (!idle_on)
			return 0;
		return int'($urandom_range(0, 16));
	endfunction

	// True when kept box i knocks out later box j.
	function automatic bit knocks_out(int i, int j);
		longint lo, hi, w, h, inter, uni;
		lo = (st_x1[i] < st_x1[j]) ? longint'(st_x1[i]) : longint'(st_x1[j]);
		hi = (st_x0[i] > st_x0[j]) ? longint'(st_x0[i]) : longint'(st_x0[j]);
		w = lo - hi + longint'(eps_cfg);
		if (w <= 0)
			return 1'b0;
		lo = (st_y1[i] < st_y1[j]) ? longint'(st_y1[i]) : longint'(st_y1[j]);
		hi = (st_y0[i] > st_y0[j]) ? longint'(st_y0[i]) : longint'(st_y0[j]);
		h = lo - hi + longint'(eps_cfg);
		if (h <= 0)
			return 1'b0;
		inter = w * h;
		uni = longint'(st_area[i]) + longint'(st_area[j]) - inter;
		if (uni <= 0)
			return 1'b0;
		return inter * 65536 >= longint'(thr_cfg) * uni;
	endfunction

	// Stores an accepted box; a closing box runs the greedy pass and queues the kept indices.
	task automatic absorb_box(input box_t b);
		int kept_list[$];
		bit gone [NBOX];
		longint wdt, hgt;
		kept_t r;
		if (set_len < NBOX) begin
			st_x0[set_len] = b.x0;
			st_y0[set_len] = b.y0;
			st_x1[set_len] = b.x1;
			st_y1[set_len] = b.y1;
			wdt = longint'(b.x1) - longint'(b.x0) + longint'(eps_cfg);
			hgt = longint'(b.y1) - longint'(b.y0) + longint'(eps_cfg);
			st_area[set_len] = 36'(wdt * hgt);
			set_len++;
		end else
			set_dropped = 1'b1;
		if (!b.last)
			return;
		for (int i = 0; i < set_len; i++) begin
			if (!gone[i]) begin
				kept_list.push_back(i);
				for (int j = i + 1; j < set_len; j++) begin
					if (!gone[j] && knocks_out(i, j))
						gone[j] = 1'b1;
				end
			end
		end
		for (int k = 0; k < kept_list.size(); k++) begin
			r.idx = anms_pkg::kept_idx_t'(kept_list[k]);
			r.fin = (k == kept_list.size() - 1);
			r.total = r.fin ? anms_pkg::kept_tot_t'(kept_list.size()) : '0;
			r.ovf = set_dropped;
			kept_q.push_back(r);
		end
		set_len = 0;
		set_dropped = 1'b0;
	endtask

	task automatic add_box(input int x0, input int y0, input int x1, input int y1,
			input bit last);
		box_t b;
		b.x0 = 16'(x0);
		b.y0 = 16'(y0);
		b.x1 = 16'(x1);
		b.y1 = 16'(y1);
		b.last = last;
		box_q.push_back(b);
		boxes_queued++;
	endtask

	// A set of n boxes, mostly clustered so that they overlap, some inverted or fully random.
	task automatic add_random_set(input int n);
		int bx, by, kind, x0, y0, x1, y1, t;
		bx = $urandom_range(0, 60000) - 30000;
		by = $urandom_range(0, 60000) - 30000;
		for (int k = 0; k < n; k++) begin
			kind = $urandom_range(0, 9);
			if (kind == 0) begin
				x0 = $urandom_range(0, 65535) - 32768;
				y0 = $urandom_range(0, 65535) - 32768;
				x1 = $urandom_range(0, 65535) - 32768;
				y1 = $urandom_range(0, 65535) - 32768;
			end else begin
				x0 = bx + $urandom_range(0, 400);
				y0 = by + $urandom_range(0, 400);
				x1 = x0 + $urandom_range(0, 300);
				y1 = y0 + $urandom_range(0, 300);
				if (kind == 1) begin
					t = x0;
					x0 = x1;
					x1 = t;
				end
			end
			add_box(x0, y0, x1, y1, k == n - 1);
		end
	endtask

	task automatic write_reg(input anms_pkg::cfg_reg_t idx,
			input logic [anms_pkg::CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == anms_pkg::REG_IOU_THRESHOLD)
			thr_cfg = val[anms_pkg::THR_W-1:0];
		else
			eps_cfg = val[anms_pkg::EPS_W-1:0];
	endtask

	// Waits until every queued box is taken and every kept index has come, then lets
	// the compare pipeline settle.
	task automatic drain_all();
		while (boxes_taken != boxes_queued || kept_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic report_miss(input string field, input logic [15:0] want,
			input logic [15:0] got);
		miss_cnt++;
		if (miss_cnt <= 10)
			$display("%0t: %s mismatch, expected %0h, got %0h", $realtime, field, want, got);
	endtask

	// Box driver: presents queued boxes with a random gap after each one.
	always @(posedge clk or negedge arst_n) begin : drive_boxes
		box_t nb;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			src_wait <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				absorb_box(cur_box);
				boxes_taken++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (src_wait != 0) begin
					s_axis_tvalid <= 1'b0;
					src_wait <= src_wait - 1;
				end else if (box_q.size() != 0) begin
					nb = box_q.pop_front();
					cur_box <= nb;
					s_axis_tdata <= {nb.y1, nb.x1, nb.y0, nb.x0};
					s_axis_tlast <= nb.last;
					s_axis_tvalid <= 1'b1;
					src_wait <= draw_gap(src_idle_on);
				end else
					s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Result monitor: checks each kept index and stalls the output at random.
	always @(posedge clk or negedge arst_n) begin : watch_results
		kept_t want;
		int hold;
		if (!arst_n) begin
			m_axis_tready <= 1'b1;
			snk_wait <= 0;
		end else if (m_axis_tvalid && m_axis_tready) begin
			if (kept_q.size() == 0) begin
				report_miss("unexpected result", '0, m_axis_tdata);
			end else begin
				want = kept_q.pop_front();
				if (m_axis_tdata[anms_pkg::OUT_IDX_LSB +: anms_pkg::KEPT_IDX_W] !== want.idx)
					report_miss("kept_index", 16'(want.idx),
						16'(m_axis_tdata[anms_pkg::OUT_IDX_LSB +: anms_pkg::KEPT_IDX_W]));
				if (m_axis_tdata[anms_pkg::OUT_TOT_LSB +: anms_pkg::KEPT_TOT_W] !== want.total)
					report_miss("kept_total", 16'(want.total),
						16'(m_axis_tdata[anms_pkg::OUT_TOT_LSB +: anms_pkg::KEPT_TOT_W]));
				if (m_axis_tdata[anms_pkg::OUT_OVF_BIT] !== want.ovf)
					report_miss("overflow", 16'(want.ovf),
						16'(m_axis_tdata[anms_pkg::OUT_OVF_BIT]));
				if (m_axis_tlast !== want.fin)
					report_miss("is_last", 16'(want.fin), 16'(m_axis_tlast));
				if (m_axis_tdata[anms_pkg::OUT_TDATA_W-1:anms_pkg::OUT_OVF_BIT+1] !== '0)
					report_miss("padding", '0,
						16'(m_axis_tdata[anms_pkg::OUT_TDATA_W-1:anms_pkg::OUT_OVF_BIT+1]));
			end
			hold = draw_gap(snk_idle_on);
			if (hold != 0) begin
				m_axis_tready <= 1'b0;
				snk_wait <= hold;
			end
		end else if (!m_axis_tready) begin
			if (snk_wait <= 1) begin
				m_axis_tready <= 1'b1;
				snk_wait <= 0;
			end else
				snk_wait <= snk_wait - 1;
		end
	end

	// Watchdog on cycles in which no request of any channel is accepted.
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("axis_aligned_box_nms_top_tb: FAIL");
			$finish;
		end else
			stall_cycles <= stall_cycles + 1;
	end

	// Stimulus: directed sets under the extreme settings, an overflow set, then random phases.
	initial begin
		int made, n;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: extreme single box, then equal, half, below-half, touching,
		// flat-overlap and inverted boxes.
		add_box(-32768, -32768, 32767, 32767, 1'b1);
		add_box(0, 0, 64, 64, 1'b0);
		add_box(0, 0, 64, 64, 1'b0);
		add_box(0, 0, 64, 32, 1'b0);
		add_box(0, 0, 64, 31, 1'b0);
		add_box(64, 0, 128, 64, 1'b0);
		add_box(0, 64, 64, 128, 1'b0);
		add_box(100, 100, 50, 50, 1'b1);
		drain_all();

		// Zero threshold with the widest padding: any padded overlap suppresses.
		write_reg(anms_pkg::REG_IOU_THRESHOLD, 17'd0);
		write_reg(anms_pkg::REG_EPS_OFFSET, 17'd255);
		add_box(0, 0, 0, 0, 1'b0);
		add_box(0, 0, 0, 0, 1'b0);
		add_box(300, 300, 300, 300, 1'b0);
		add_box(10, 10, 5, 5, 1'b0);
		add_box(32767, 32767, -32768, -32768, 1'b1);
		drain_all();

		// Threshold of exactly one: only a perfect match suppresses.
		src_idle_on = 1'b0;
		snk_idle_on = 1'b0;
		write_reg(anms_pkg::REG_IOU_THRESHOLD, 17'd65536);
		write_reg(anms_pkg::REG_EPS_OFFSET, 17'd0);
		add_box(0, 0, 100, 100, 1'b0);
		add_box(0, 0, 100, 100, 1'b0);
		add_box(0, 0, 100, 99, 1'b1);
		drain_all();

		// Threshold above one never suppresses.
		src_idle_on = 1'b1;
		write_reg(anms_pkg::REG_IOU_THRESHOLD, 17'd131071);
		add_box(0, 0, 100, 100, 1'b0);
		add_box(0, 0, 100, 100, 1'b0);
		add_box(0, 0, 100, 99, 1'b1);
		drain_all();

		// Overflow: the closing box is dropped; the next sets must start clean.
		snk_idle_on = 1'b1;
		write_reg(anms_pkg::REG_IOU_THRESHOLD, 17'd32768);
		write_reg(anms_pkg::REG_EPS_OFFSET, 17'd3);
		add_random_set(NBOX + 1);
		add_random_set(2);
		add_random_set(NBOX);
		drain_all();

		// Random phases, each under its own settings and idling mix.
		for (int ph = 0; ph < 4; ph++) begin
			if ($urandom_range(0, 3) == 0)
				write_reg(anms_pkg::REG_IOU_THRESHOLD, 17'($urandom_range(0, 131071)));
			else
				write_reg(anms_pkg::REG_IOU_THRESHOLD, 17'($urandom_range(16384, 52428)));
			if ($urandom_range(0, 1) == 0)
				write_reg(anms_pkg::REG_EPS_OFFSET, 17'd0);
			else
				write_reg(anms_pkg::REG_EPS_OFFSET, 17'($urandom_range(0, 255)));
			src_idle_on = ($urandom_range(0, 2) != 0);
			snk_idle_on = ($urandom_range(0, 2) != 0);
			made = 0;
			while (made < 20) begin
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 64) : $urandom_range(1, 10);
				add_random_set(n);
				made += n;
			end
			drain_all();
		end

		repeat (40) @(posedge clk);
		if (miss_cnt == 0 && kept_q.size() == 0)
			$display("axis_aligned_box_nms_top_tb: PASS");
		else
			$display("axis_aligned_box_nms_top_tb: FAIL");
		$finish;
	end

endmodule
